// ===== src/ipv6_napt_header_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// ipv6 napt header extractor assertion macros
// shared property forms for the extractor modules, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef IPV6_NAPT_HEADER_EXTRACTOR_ASSERT_SVH
`define IPV6_NAPT_HEADER_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define IPV6NH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv6nh assertion failed");

// next-cycle implication
`define IPV6NH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv6nh assertion failed");

`endif

// ===== src/ipv6nh_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv6nh_pkg
// types, codes and helpers shared by the ipv6 next-header chain extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipv6nh_pkg;

    // byte offset counter width and its saturation value
    localparam int OFFSET_BITS = 16;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    localparam offset_t OFF_MAX = '1;

    // width that holds a header start plus the longest extension header
    localparam int SUM_W = ((OFFSET_BITS > 11) ? OFFSET_BITS : 11) + 1;
    typedef logic [SUM_W-1:0] offset_sum_t;

    localparam int FIXED_LEN = 40;
    localparam int EXT_UNIT  = 8;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FRAG   = 3'd1;
    localparam logic [2:0] ST_UNSUP  = 3'd2;
    localparam logic [2:0] ST_ICMP   = 3'd3;
    localparam logic [2:0] ST_BADERR = 3'd4;
    localparam logic [2:0] ST_TRUNC  = 3'd5;

    // next-header codes
    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] NH_UDP   = 8'd17;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG  = 8'd44;
    localparam logic [7:0] NH_ICMP  = 8'd58;
    localparam logic [7:0] NH_DEST  = 8'd60;

    // icmpv6 message types
    localparam logic [7:0] ICMP_ERR_MIN   = 8'd1;
    localparam logic [7:0] ICMP_ERR_MAX   = 8'd4;
    localparam logic [7:0] ICMP_ECHO_REQ  = 8'd128;
    localparam logic [7:0] ICMP_ECHO_REPL = 8'd129;

    // parse phases
    typedef enum logic [5:0] {
        PH_FIXED = 6'b000001,
        PH_EXT   = 6'b000010,
        PH_L4    = 6'b000100,
        PH_ICMP  = 6'b001000,
        PH_ERR   = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       direction;
        logic       last_byte;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  protocol;
        logic [15:0] l4_offset;
        logic [63:0] address_hi;
        logic [63:0] address_lo;
        logic [15:0] port_or_id;
        logic [15:0] peer_port;
    } out_beat_t;

    // icmpv6 error message types
    function automatic logic is_error_type(input logic [7:0] t);
        return (t >= ICMP_ERR_MIN) && (t <= ICMP_ERR_MAX);
    endfunction

endpackage

`default_nettype wire

// ===== src/ipv6nh_parser.sv =====
// ----------------------------------------------------------------------------
// ipv6nh_parser
// per-byte next-header chain walker; gives the packet result on the last beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ipv6_napt_header_extractor_assert.svh"

module ipv6nh_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                beat_en,
    input  wire ipv6nh_pkg::in_beat_t beat,
    output logic                     res_valid,
    output ipv6nh_pkg::out_beat_t    res
);

    ipv6nh_pkg::offset_t pos_reg, pos_next;
    ipv6nh_pkg::offset_t hstart_reg, hstart_next;
    logic [7:0]          pnh_reg, pnh_next;
    ipv6nh_pkg::phase_t  phase_reg, phase_next;
    logic                dir_reg, dir_next;
    logic [127:0]        osrc_reg, osrc_next;
    logic [127:0]        odst_reg, odst_next;
    logic [127:0]        isrc_reg, isrc_next;
    logic [7:0]          mtype_reg, mtype_next;
    logic [7:0]          inh_reg, inh_next;
    logic [15:0]         port1_reg, port1_next;
    logic [15:0]         port2_reg, port2_next;
    logic [2:0]          verdict_reg, verdict_next;
    logic [7:0]          fproto_reg, fproto_next;
    ipv6nh_pkg::offset_t foff_reg, foff_next;

    ipv6nh_pkg::offset_t     rel;
    ipv6nh_pkg::offset_sum_t ext_sum;
    ipv6nh_pkg::offset_t     ext_start;
    logic                    is_early;
    logic                    do_dispatch;
    logic [7:0]              b;

    // next state for one beat
    always_comb
    begin
        pos_next     = pos_reg;
        hstart_next  = hstart_reg;
        pnh_next     = pnh_reg;
        phase_next   = phase_reg;
        osrc_next    = osrc_reg;
        odst_next    = odst_reg;
        isrc_next    = isrc_reg;
        mtype_next   = mtype_reg;
        inh_next     = inh_reg;
        port1_next   = port1_reg;
        port2_next   = port2_reg;
        verdict_next = verdict_reg;
        fproto_next  = fproto_reg;
        foff_next    = foff_reg;
        do_dispatch  = 1'b0;
        b            = beat.data_byte;

        dir_next  = (pos_reg == '0) ? beat.direction : dir_reg;
        rel       = pos_reg - hstart_reg;
        is_early  = pos_reg < hstart_reg;
        ext_sum   = ipv6nh_pkg::offset_sum_t'(hstart_reg)
                  + (ipv6nh_pkg::offset_sum_t'(b) + ipv6nh_pkg::offset_sum_t'(1))
                  * ipv6nh_pkg::offset_sum_t'(ipv6nh_pkg::EXT_UNIT);
        ext_start = (ext_sum > ipv6nh_pkg::offset_sum_t'(ipv6nh_pkg::OFF_MAX))
                  ? ipv6nh_pkg::OFF_MAX : ext_sum[ipv6nh_pkg::OFFSET_BITS-1:0];

        if (pos_reg != ipv6nh_pkg::OFF_MAX)
        begin
            pos_next = pos_reg + ipv6nh_pkg::offset_t'(1);

            unique case (phase_reg)
                ipv6nh_pkg::PH_FIXED:
                begin
                    if (pos_reg == ipv6nh_pkg::offset_t'(6))
                        pnh_next = b;
                    else if (pos_reg >= ipv6nh_pkg::offset_t'(8)
                             && pos_reg < ipv6nh_pkg::offset_t'(24))
                        osrc_next = {osrc_reg[119:0], b};
                    else if (pos_reg >= ipv6nh_pkg::offset_t'(24)
                             && pos_reg < ipv6nh_pkg::offset_t'(ipv6nh_pkg::FIXED_LEN))
                        odst_next = {odst_reg[119:0], b};
                    if (pos_reg == ipv6nh_pkg::offset_t'(ipv6nh_pkg::FIXED_LEN - 1))
                    begin
                        hstart_next = ipv6nh_pkg::offset_t'(ipv6nh_pkg::FIXED_LEN);
                        do_dispatch = 1'b1;
                    end
                end
                ipv6nh_pkg::PH_EXT:
                begin
                    if (!is_early)
                    begin
                        if (rel == ipv6nh_pkg::offset_t'(0))
                            pnh_next = b;
                        else if (rel == ipv6nh_pkg::offset_t'(1))
                        begin
                            hstart_next = ext_start;
                            do_dispatch = 1'b1;
                        end
                    end
                end
                ipv6nh_pkg::PH_L4:
                begin
                    if (!is_early)
                    begin
                        if (rel < ipv6nh_pkg::offset_t'(2))
                            port1_next = {port1_reg[7:0], b};
                        else if (rel < ipv6nh_pkg::offset_t'(4))
                            port2_next = {port2_reg[7:0], b};
                        if (rel == ipv6nh_pkg::offset_t'(3))
                        begin
                            verdict_next = ipv6nh_pkg::ST_OK;
                            phase_next   = ipv6nh_pkg::PH_DONE;
                        end
                    end
                end
                ipv6nh_pkg::PH_ICMP:
                begin
                    if (!is_early)
                    begin
                        if (rel == ipv6nh_pkg::offset_t'(0))
                        begin
                            mtype_next = b;
                            if (!(ipv6nh_pkg::is_error_type(b)
                                  || b == ipv6nh_pkg::ICMP_ECHO_REQ
                                  || b == ipv6nh_pkg::ICMP_ECHO_REPL))
                            begin
                                verdict_next = ipv6nh_pkg::ST_ICMP;
                                phase_next   = ipv6nh_pkg::PH_DONE;
                            end
                        end
                        else if (rel == ipv6nh_pkg::offset_t'(4)
                                 || rel == ipv6nh_pkg::offset_t'(5))
                        begin
                            port1_next = {port1_reg[7:0], b};
                            if (rel == ipv6nh_pkg::offset_t'(5))
                            begin
                                if (dir_reg && ipv6nh_pkg::is_error_type(mtype_reg))
                                    phase_next = ipv6nh_pkg::PH_ERR;
                                else
                                begin
                                    verdict_next = ipv6nh_pkg::ST_OK;
                                    phase_next   = ipv6nh_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                end
                ipv6nh_pkg::PH_ERR:
                begin
                    // quoted inner packet starts 8 bytes into the icmp header
                    if (rel == ipv6nh_pkg::offset_t'(14))
                    begin
                        inh_next = b;
                        if (b == ipv6nh_pkg::NH_TCP || b == ipv6nh_pkg::NH_UDP)
                            fproto_next = b;
                        else if (b != ipv6nh_pkg::NH_ICMP)
                        begin
                            verdict_next = ipv6nh_pkg::ST_BADERR;
                            phase_next   = ipv6nh_pkg::PH_DONE;
                        end
                    end
                    else if (rel >= ipv6nh_pkg::offset_t'(16)
                             && rel < ipv6nh_pkg::offset_t'(32))
                        isrc_next = {isrc_reg[119:0], b};
                    else if (inh_reg == ipv6nh_pkg::NH_ICMP
                             && (rel == ipv6nh_pkg::offset_t'(52)
                                 || rel == ipv6nh_pkg::offset_t'(53)))
                    begin
                        port1_next = {port1_reg[7:0], b};
                        if (rel == ipv6nh_pkg::offset_t'(53))
                        begin
                            verdict_next = ipv6nh_pkg::ST_OK;
                            phase_next   = ipv6nh_pkg::PH_DONE;
                        end
                    end
                    else if (inh_reg != ipv6nh_pkg::NH_ICMP
                             && (rel == ipv6nh_pkg::offset_t'(48)
                                 || rel == ipv6nh_pkg::offset_t'(49)))
                    begin
                        port1_next = {port1_reg[7:0], b};
                        if (rel == ipv6nh_pkg::offset_t'(49))
                        begin
                            verdict_next = ipv6nh_pkg::ST_OK;
                            phase_next   = ipv6nh_pkg::PH_DONE;
                        end
                    end
                end
                default:
                begin
                    // finished: remaining bytes are ignored
                end
            endcase

            // act on the pending next header at the new header start
            if (do_dispatch)
            begin
                case (pnh_reg) inside
                    ipv6nh_pkg::NH_HOP, ipv6nh_pkg::NH_ROUTE, ipv6nh_pkg::NH_DEST:
                        phase_next = ipv6nh_pkg::PH_EXT;
                    ipv6nh_pkg::NH_FRAG:
                    begin
                        verdict_next = ipv6nh_pkg::ST_FRAG;
                        phase_next   = ipv6nh_pkg::PH_DONE;
                    end
                    ipv6nh_pkg::NH_TCP, ipv6nh_pkg::NH_UDP:
                    begin
                        fproto_next = pnh_reg;
                        foff_next   = hstart_next;
                        phase_next  = ipv6nh_pkg::PH_L4;
                    end
                    ipv6nh_pkg::NH_ICMP:
                    begin
                        fproto_next = pnh_reg;
                        foff_next   = hstart_next;
                        phase_next  = ipv6nh_pkg::PH_ICMP;
                    end
                    default:
                    begin
                        verdict_next = ipv6nh_pkg::ST_UNSUP;
                        phase_next   = ipv6nh_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    // result assembly on the last beat
    always_comb
    begin
        res_valid = beat_en && beat.last_byte;
        res       = '0;
        res.status = verdict_next;
        if (verdict_next == ipv6nh_pkg::ST_OK)
        begin
            res.protocol  = fproto_next;
            res.l4_offset = 16'(foff_next);
            if (dir_next && foff_next != '0 && ipv6nh_pkg::is_error_type(mtype_next))
            begin
                res.address_hi = isrc_next[127:64];
                res.address_lo = isrc_next[63:0];
                res.port_or_id = port1_next;
            end
            else if (!dir_next)
            begin
                res.address_hi = osrc_next[127:64];
                res.address_lo = osrc_next[63:0];
                res.port_or_id = port1_next;
                if (fproto_next != ipv6nh_pkg::NH_ICMP)
                    res.peer_port = port2_next;
            end
            else
            begin
                res.address_hi = odst_next[127:64];
                res.address_lo = odst_next[63:0];
                res.port_or_id = (fproto_next == ipv6nh_pkg::NH_ICMP) ? port1_next : port2_next;
            end
        end
    end

    // control state, back to its packet-start values after each last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hstart_reg  <= '0;
            pnh_reg     <= '0;
            phase_reg   <= ipv6nh_pkg::PH_FIXED;
            dir_reg     <= 1'b0;
            mtype_reg   <= '0;
            inh_reg     <= '0;
            verdict_reg <= ipv6nh_pkg::ST_TRUNC;
            fproto_reg  <= '0;
            foff_reg    <= '0;
        end
        else if (beat_en)
        begin
            if (beat.last_byte)
            begin
                pos_reg     <= '0;
                hstart_reg  <= '0;
                pnh_reg     <= '0;
                phase_reg   <= ipv6nh_pkg::PH_FIXED;
                dir_reg     <= 1'b0;
                mtype_reg   <= '0;
                inh_reg     <= '0;
                verdict_reg <= ipv6nh_pkg::ST_TRUNC;
                fproto_reg  <= '0;
                foff_reg    <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                hstart_reg  <= hstart_next;
                pnh_reg     <= pnh_next;
                phase_reg   <= phase_next;
                dir_reg     <= dir_next;
                mtype_reg   <= mtype_next;
                inh_reg     <= inh_next;
                verdict_reg <= verdict_next;
                fproto_reg  <= fproto_next;
                foff_reg    <= foff_next;
            end
        end
    end

    // captured addresses and ports, always fully rewritten before use
    always_ff @(posedge clk)
    begin
        if (beat_en)
        begin
            osrc_reg  <= osrc_next;
            odst_reg  <= odst_next;
            isrc_reg  <= isrc_next;
            port1_reg <= port1_next;
            port2_reg <= port2_next;
        end
    end

    `IPV6NH_ASSERT_NEXT(a_restart_after_last, beat_en && beat.last_byte,
        pos_reg == '0 && phase_reg == ipv6nh_pkg::PH_FIXED)
    `IPV6NH_ASSERT_IMPL(a_verdict_means_done, verdict_reg != ipv6nh_pkg::ST_TRUNC,
        phase_reg == ipv6nh_pkg::PH_DONE)
    `IPV6NH_ASSERT_IMPL(a_ok_protocol, res_valid && res.status == ipv6nh_pkg::ST_OK,
        res.protocol == ipv6nh_pkg::NH_TCP || res.protocol == ipv6nh_pkg::NH_UDP
        || res.protocol == ipv6nh_pkg::NH_ICMP)

endmodule

`default_nettype wire

// ===== src/ipv6_napt_header_extractor.sv =====
// ----------------------------------------------------------------------------
// ipv6_napt_header_extractor
// walks the ipv6 extension header chain of a byte stream and reports the
// transport protocol, offset, address and ports of each packet
// ----------------------------------------------------------------------------
//   channel   dir   handshake                      beat
//   byte      in    byte_valid / byte_ready        in_beat_t, one packet byte
//   result    out   result_valid / result_ready    out_beat_t, one per packet
//
// one byte per cycle while byte_ready is high; the parse is one pass of compare logic
// the result of a packet is registered into the output stage from its last byte
// a two-entry output stage (result register and skid) keeps bytes flowing
// while a result waits; byte_ready drops only when both entries are full
// reset returns the parser to the start of a packet with no result pending
`timescale 1ns / 1ps
`default_nettype none

`include "ipv6_napt_header_extractor_assert.svh"

module ipv6_napt_header_extractor (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire ipv6nh_pkg::in_beat_t byte_beat,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output ipv6nh_pkg::out_beat_t     result_beat
);

    logic                  beat_en;
    logic                  res_valid;
    ipv6nh_pkg::out_beat_t res;

    logic                  out_valid_reg, out_valid_next;
    ipv6nh_pkg::out_beat_t out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    ipv6nh_pkg::out_beat_t skid_data_reg, skid_data_next;

    assign byte_ready   = !skid_valid_reg;
    assign beat_en      = byte_valid && byte_ready;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_data_reg;

    ipv6nh_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_en   (beat_en),
        .beat      (byte_beat),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
                out_data_next = res;
            else
                out_valid_next = 1'b0;
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `IPV6NH_ASSERT_IMPL(a_skid_needs_main, skid_valid_reg, out_valid_reg)
    `IPV6NH_ASSERT_NEXT(a_skid_fills, res_valid && out_valid_reg && !result_ready,
        skid_valid_reg)
    `IPV6NH_ASSERT_IMPL(a_reject_clears_fields,
        out_valid_reg && out_data_reg.status != ipv6nh_pkg::ST_OK,
        out_data_reg.protocol == '0 && out_data_reg.l4_offset == '0
        && out_data_reg.address_hi == '0 && out_data_reg.address_lo == '0
        && out_data_reg.port_or_id == '0 && out_data_reg.peer_port == '0)

endmodule

`default_nettype wire
